@@ src/byte_ring_fifo_defines.svh @@
// ----------------------------------------------------------------------------
// byte ring fifo assertion macros
// shared concurrent assertion wrappers, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_DEFINES_SVH
`define BYTE_RING_FIFO_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define BRF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must hold in the cycle after the trigger
`define BRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/brf_pkg.sv @@
// ----------------------------------------------------------------------------
// brf_pkg
// shared types and constants of the byte ring fifo
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int unsigned DEPTH   = 64;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned PTR_W   = IDX_W + 1;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned MAX_RUN = 64;
  localparam int unsigned CMP_W   = (PTR_W > LEN_W) ? PTR_W : LEN_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUT        = 3'd0,
    OP_GET        = 3'd1,
    OP_PEEK       = 3'd2,
    OP_PULL       = 3'd3,
    OP_PEEK_AHEAD = 3'd4,
    OP_FLUSH      = 3'd5,
    OP_ADD        = 3'd6
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic do_single;
    logic run_start;
    logic run_emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic run_nonzero;
    logic out_free;
    logic run_last;
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              data_valid;
    logic              accepted;
    logic [LEN_W-1:0]  occupancy;
    logic              is_full;
    logic              is_empty;
    logic              last_of_run;
    logic [LEN_W-1:0]  transferred;
  } result_t;

endpackage

@@ src/brf_in_if.sv @@
// ----------------------------------------------------------------------------
// brf_in_if
// request channel of the byte ring fifo
// ----------------------------------------------------------------------------
interface brf_in_if;
  logic                        valid;
  logic                        ready;
  logic [brf_pkg::OP_W-1:0]    operation;
  logic [brf_pkg::DATA_W-1:0]  data_in;
  logic [brf_pkg::LEN_W-1:0]   request_length;
  logic                        burst_first;
  logic [brf_pkg::LEN_W-1:0]   burst_length;

  modport source (
    output valid, operation, data_in, request_length, burst_first, burst_length,
    input  ready
  );
  modport sink (
    input  valid, operation, data_in, request_length, burst_first, burst_length,
    output ready
  );
endinterface

@@ src/brf_out_if.sv @@
// ----------------------------------------------------------------------------
// brf_out_if
// result channel of the byte ring fifo
// ----------------------------------------------------------------------------
interface brf_out_if;
  logic                        valid;
  logic                        ready;
  logic [brf_pkg::DATA_W-1:0]  data_out;
  logic                        data_valid;
  logic                        accepted;
  logic [brf_pkg::LEN_W-1:0]   occupancy;
  logic                        is_full;
  logic                        is_empty;
  logic                        last_of_run;
  logic [brf_pkg::LEN_W-1:0]   transferred;

  modport source (
    output valid, data_out, data_valid, accepted, occupancy, is_full, is_empty,
           last_of_run, transferred,
    input  ready
  );
  modport sink (
    input  valid, data_out, data_valid, accepted, occupancy, is_full, is_empty,
           last_of_run, transferred,
    output ready
  );
endinterface

@@ src/brf_ctrl.sv @@
// ----------------------------------------------------------------------------
// brf_ctrl
// sequencer: capture, execute, then give a single result or emit a run of read beats
// ----------------------------------------------------------------------------
module brf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  brf_pkg::status_t status_i,
  output brf_pkg::cmd_t    cmd_o
);
  import brf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RUN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status_i.run_nonzero) begin
          cmd_o.run_start = 1'b1;
          state_d         = S_RUN;
        end else if (status_i.out_free) begin
          cmd_o.do_single = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_RUN: begin
        if (status_i.out_free) begin
          cmd_o.run_emit = 1'b1;
          if (status_i.run_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/brf_dpath.sv @@
// ----------------------------------------------------------------------------
// brf_dpath
// pointers, byte ring, burst tracking and result register
// ----------------------------------------------------------------------------
`include "byte_ring_fifo_defines.svh"

module brf_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  brf_pkg::cmd_t               cmd_i,
  output brf_pkg::status_t            status_o,
  input  logic [brf_pkg::OP_W-1:0]    operation_i,
  input  logic [brf_pkg::DATA_W-1:0]  data_in_i,
  input  logic [brf_pkg::LEN_W-1:0]   request_length_i,
  input  logic                        burst_first_i,
  input  logic [brf_pkg::LEN_W-1:0]   burst_length_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output brf_pkg::result_t            result_o
);
  import brf_pkg::*;

  // captured item
  logic [OP_W-1:0]   op_q;
  logic [DATA_W-1:0] din_q;
  logic [LEN_W-1:0]  req_q;
  logic              first_q;
  logic [LEN_W-1:0]  blen_q;

  logic [PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic              adm_q, adm_d, adm_e;
  logic [LEN_W-1:0]  rem_q, rem_d, rem_e;

  logic [PTR_W-1:0]  run_p_q;
  logic [LEN_W-1:0]  run_n_q, run_i_q, run_n_c, run_i_inc;
  logic              run_last;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  raddr;

  logic              out_valid_q;
  result_t           res_q, res_d;

  op_e               op;
  logic [PTR_W-1:0]  held, occ_after;
  logic [CMP_W-1:0]  held_c, space_c, min_a, min_b;
  logic              full, acc, advance, report, out_free;

  assign op     = op_e'(op_q);
  assign held   = wp_q - rp_q;
  assign held_c = CMP_W'(held);
  assign full   = held_c >= CMP_W'(DEPTH);
  assign space_c = CMP_W'(DEPTH) - held_c;

  assign advance = (op == OP_GET) || (op == OP_PULL);
  assign report  = (op == OP_PULL) || (op == OP_PEEK_AHEAD);

  // run length: least of request, occupancy and the run cap
  assign min_a = (held_c < CMP_W'(req_q)) ? held_c : CMP_W'(req_q);
  assign min_b = (min_a < CMP_W'(MAX_RUN)) ? min_a : CMP_W'(MAX_RUN);

  always_comb begin
    case (op) inside
      OP_GET, OP_PEEK:         run_n_c = (held != '0) ? LEN_W'(1) : '0;
      OP_PULL, OP_PEEK_AHEAD:  run_n_c = LEN_W'(min_b);
      default:                 run_n_c = '0;
    endcase
  end

  assign run_i_inc = run_i_q + LEN_W'(1);
  assign run_last  = run_i_inc == run_n_q;
  assign out_free  = !out_valid_q || out_ready_i;

  assign status_o.run_nonzero = run_n_c != '0;
  assign status_o.out_free    = out_free;
  assign status_o.run_last    = run_last;

  // state update for single-result items and run beats
  always_comb begin
    wp_d   = wp_q;
    rp_d   = rp_q;
    adm_d  = adm_q;
    rem_d  = rem_q;
    adm_e  = adm_q;
    rem_e  = rem_q;
    mem_we = 1'b0;
    acc    = 1'b0;
    if (cmd_i.do_single) begin
      case (op)
        OP_PUT: begin
          if (!full) begin
            mem_we = 1'b1;
            wp_d   = wp_q + PTR_W'(1);
            acc    = 1'b1;
          end
        end
        OP_FLUSH: rp_d = wp_q;
        OP_ADD: begin
          if (first_q) begin
            adm_e = (blen_q != '0) && (CMP_W'(blen_q) <= space_c);
            rem_e = adm_e ? blen_q : '0;
          end
          adm_d = adm_e;
          rem_d = rem_e;
          if (adm_e && (rem_e != '0)) begin
            // a full ring drops the byte but it still counts
            if (!full) begin
              mem_we = 1'b1;
              wp_d   = wp_q + PTR_W'(1);
              acc    = 1'b1;
            end
            rem_d = rem_e - LEN_W'(1);
            if (rem_e == LEN_W'(1)) begin
              adm_d = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.run_emit && advance) begin
      rp_d = run_p_q + PTR_W'(1);
    end
  end

  assign occ_after = wp_d - rp_d;

  always_comb begin
    res_d             = res_q;
    res_d.occupancy   = LEN_W'(occ_after);
    res_d.is_full     = occ_after == PTR_W'(DEPTH);
    res_d.is_empty    = occ_after == '0;
    if (cmd_i.run_emit) begin
      res_d.data_out    = rdata_q;
      res_d.data_valid  = 1'b1;
      res_d.accepted    = 1'b0;
      res_d.last_of_run = run_last;
      res_d.transferred = (run_last && report) ? run_n_q : '0;
    end else begin
      res_d.data_out    = '0;
      res_d.data_valid  = 1'b0;
      res_d.accepted    = acc;
      res_d.last_of_run = 1'b1;
      res_d.transferred = '0;
    end
  end

  // read the front at run start, then one ahead on every beat
  assign mem_re = cmd_i.run_start || cmd_i.run_emit;
  assign raddr  = cmd_i.run_start ? rp_q[IDX_W-1:0] : IDX_W'(run_p_q + PTR_W'(1));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp_q[IDX_W-1:0]] <= din_q;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= operation_i;
      din_q   <= data_in_i;
      req_q   <= request_length_i;
      first_q <= burst_first_i;
      blen_q  <= burst_length_i;
    end
    if (cmd_i.do_single || cmd_i.run_emit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      rp_q        <= '0;
      adm_q       <= 1'b0;
      rem_q       <= '0;
      run_p_q     <= '0;
      run_n_q     <= '0;
      run_i_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      adm_q <= adm_d;
      rem_q <= rem_d;
      if (cmd_i.run_start) begin
        run_p_q <= rp_q;
        run_n_q <= run_n_c;
        run_i_q <= '0;
      end else if (cmd_i.run_emit) begin
        run_p_q <= run_p_q + PTR_W'(1);
        run_i_q <= run_i_inc;
      end
      if (cmd_i.do_single || cmd_i.run_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  `BRF_ASSERT(a_occ_bound, CMP_W'(wp_q - rp_q) <= CMP_W'(DEPTH), "occupancy above depth")
  `BRF_ASSERT(a_beat_in_run, cmd_i.run_emit |-> (run_i_q < run_n_q), "beat past run end")
  `BRF_ASSERT_NEXT(a_flush_empty, cmd_i.do_single && (op == OP_FLUSH), wp_q == rp_q, "flush left bytes")
  `BRF_ASSERT(a_xfer_last, (out_valid_q && (res_q.transferred != '0)) |-> res_q.last_of_run, "count off last beat")

endmodule

@@ src/byte_ring_fifo.sv @@
// ----------------------------------------------------------------------------
// byte_ring_fifo
// byte fifo over a 64-entry ring with free-running pointers
// ----------------------------------------------------------------------------
// in_i carries one request beat: put, get, peek, pull, peek ahead, flush or
// one byte of an all-or-nothing add burst (length on the first byte).
// out_o carries result beats: one per request, except pull and peek ahead,
// which give one beat per byte moved, the final one flagged last_of_run
// with the byte count in transferred.
// a request that returns no byte has its result beat registered in the
// execute state; a get, peek, pull or peek ahead that returns bytes reads
// the front in the execute state and registers its first beat in the run
// state, the extra state covering the registered ring read port.
// every request passes through idle and execute, and one returning bytes
// then stays in the run state for its beats; both wait while out_o stalls.
// a request is taken only when the previous one has issued all its beats;
// the result register lets the next request in while the last beat waits.
// reset clears pointers, burst tracking and the result valid flag; ring
// contents are left as they are and only bytes written are ever read.
// a stalled receiver holds the current beat and pauses any run in place.
// ----------------------------------------------------------------------------
module byte_ring_fifo (
  input  logic      clk_i,
  input  logic      rst_ni,
  brf_in_if.sink    in_i,
  brf_out_if.source out_o
);
  import brf_pkg::*;

  cmd_t    cmd;      // sequencer commands
  status_t status;   // datapath status back to the sequencer
  result_t result;   // registered result beat
  logic    out_valid;

  // sequencer
  brf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // ring, pointers and result register
  brf_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .operation_i      (in_i.operation),
    .data_in_i        (in_i.data_in),
    .request_length_i (in_i.request_length),
    .burst_first_i    (in_i.burst_first),
    .burst_length_i   (in_i.burst_length),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_o.ready),
    .result_o         (result)
  );

  // result beat onto the output channel
  assign out_o.valid       = out_valid;
  assign out_o.data_out    = result.data_out;
  assign out_o.data_valid  = result.data_valid;
  assign out_o.accepted    = result.accepted;
  assign out_o.occupancy   = result.occupancy;
  assign out_o.is_full     = result.is_full;
  assign out_o.is_empty    = result.is_empty;
  assign out_o.last_of_run = result.last_of_run;
  assign out_o.transferred = result.transferred;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the byte ring fifo
// ----------------------------------------------------------------------------
// request beats come from a directed table and then from random sequences:
// well-formed add bursts with random bytes, put runs, reads of every kind,
// broken bursts and plain noise. a cycle-free model of the ring works out
// every result beat a request causes; result beats are checked in order,
// field by field. one long stretch fills the ring with a 64-byte burst and
// runs the first full-ring cases with neither side idling.
// ----------------------------------------------------------------------------
module testbench;
  import brf_pkg::*;

  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned IDLE_PCT       = 19;
  localparam int unsigned RANDOM_ITEMS   = 86;
  localparam int unsigned FILL_AFTER     = 8;     // random requests before the full-ring run
  localparam int unsigned SETTLE_CYCLES  = 20;    // time left for any stray result beat
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned N_STEPS        = 24;

  // code 7 is not an operation: the block only reports status
  localparam logic [OP_W-1:0] OP_RESERVED = 3'd7;

  typedef logic [DATA_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [PTR_W-1:0]  ptr_t;

  typedef struct packed {
    op_e   op;
    byte_t data;
    len_t  len;
    logic  first;
    len_t  blen;
  } request_t;

  // a pinned request must produce exactly the beat written next to it
  typedef struct {
    logic    pinned;
    result_t beat;
  } pin_t;

  typedef struct {
    request_t req;
    logic     pinned;
    result_t  beat;
  } step_t;

  // {data, data valid, accepted, occupancy, full, empty, last, transferred}
  localparam result_t EMPTY_STATUS =
    {8'h00, 1'b0, 1'b0, 7'd0, 1'b0, 1'b1, 1'b1, 7'd0};

  // unpinned rows are checked against the model only
  step_t directed [N_STEPS] = '{
    // nothing held: every read comes back empty, the reserved code only reports
    '{'{OP_GET,             8'h00, 7'd0,  1'b0, 7'd0},  1'b1, EMPTY_STATUS},
    '{'{OP_PEEK,            8'hFF, 7'd64, 1'b1, 7'd64}, 1'b1, EMPTY_STATUS},
    '{'{OP_PULL,            8'h00, 7'd5,  1'b0, 7'd0},  1'b1, EMPTY_STATUS},
    '{'{OP_PEEK_AHEAD,      8'h00, 7'd64, 1'b0, 7'd0},  1'b1, EMPTY_STATUS},
    '{'{op_e'(OP_RESERVED), 8'hFF, 7'd64, 1'b1, 7'd64}, 1'b1, EMPTY_STATUS},
    // extreme bytes go in, peek sees the front one
    '{'{OP_PUT,  8'h00, 7'd0, 1'b0, 7'd0}, 1'b1,
      {8'h00, 1'b0, 1'b1, 7'd1, 1'b0, 1'b0, 1'b1, 7'd0}},
    '{'{OP_PUT,  8'hFF, 7'd0, 1'b0, 7'd0}, 1'b1,
      {8'h00, 1'b0, 1'b1, 7'd2, 1'b0, 1'b0, 1'b1, 7'd0}},
    '{'{OP_PEEK, 8'h00, 7'd0, 1'b0, 7'd0}, 1'b1,
      {8'h00, 1'b1, 1'b0, 7'd2, 1'b0, 1'b0, 1'b1, 7'd0}},
    // peek ahead asks for more than is held, pull takes the front byte
    '{'{OP_PEEK_AHEAD, 8'h00, 7'd64, 1'b0, 7'd0}, 1'b0, '0},
    '{'{OP_PULL,       8'h00, 7'd1,  1'b0, 7'd0}, 1'b0, '0},
    '{'{OP_GET,        8'h00, 7'd0,  1'b0, 7'd0}, 1'b1,
      {8'hFF, 1'b1, 1'b0, 7'd0, 1'b0, 1'b1, 1'b1, 7'd0}},
    // zero-length pull with a byte held, then flush
    '{'{OP_PUT,   8'hAA, 7'd0, 1'b0, 7'd0}, 1'b1,
      {8'h00, 1'b0, 1'b1, 7'd1, 1'b0, 1'b0, 1'b1, 7'd0}},
    '{'{OP_PULL,  8'h00, 7'd0, 1'b0, 7'd0}, 1'b1,
      {8'h00, 1'b0, 1'b0, 7'd1, 1'b0, 1'b0, 1'b1, 7'd0}},
    '{'{OP_FLUSH, 8'h00, 7'd0, 1'b0, 7'd0}, 1'b1, EMPTY_STATUS},
    // zero-length burst and a stray burst byte are both dropped
    '{'{OP_ADD, 8'h11, 7'd0, 1'b1, 7'd0}, 1'b1, EMPTY_STATUS},
    '{'{OP_ADD, 8'h22, 7'd0, 1'b0, 7'd0}, 1'b1, EMPTY_STATUS},
    // three-byte burst with a put in between, then one byte past its end
    '{'{OP_ADD, 8'hA5, 7'd0, 1'b1, 7'd3}, 1'b0, '0},
    '{'{OP_PUT, 8'h5A, 7'd0, 1'b0, 7'd0}, 1'b0, '0},
    '{'{OP_ADD, 8'h3C, 7'd0, 1'b0, 7'd0}, 1'b0, '0},
    '{'{OP_ADD, 8'hC3, 7'd0, 1'b0, 7'd0}, 1'b0, '0},
    '{'{OP_ADD, 8'h7E, 7'd0, 1'b0, 7'd0}, 1'b0, '0},
    // short peek ahead and pull over the four bytes held
    '{'{OP_PEEK_AHEAD, 8'h00, 7'd7, 1'b0, 7'd0}, 1'b0, '0},
    '{'{OP_PULL,       8'h00, 7'd2, 1'b0, 7'd0}, 1'b0, '0},
    '{'{OP_FLUSH,      8'h00, 7'd0, 1'b0, 7'd0}, 1'b1, EMPTY_STATUS}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic calm;   // no idling on either side while set

  brf_in_if  req_if ();
  brf_out_if res_if ();

  byte_ring_fifo DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (res_if)
  );

  always #1 clk_i = ~clk_i;

  // ring model: free-running pointers one bit wider than the index
  byte_t ring [DEPTH];
  ptr_t  wr_ptr     = '0;
  ptr_t  rd_ptr     = '0;
  logic  burst_open = 1'b0;
  len_t  burst_left = '0;

  result_t     beats_due [$];   // result beats still to come, oldest first
  pin_t        pin_due   [$];   // one per request sent, popped when it is taken
  int unsigned beats_outstanding = 0;
  int unsigned items_sent    = 0;
  int unsigned beats_checked = 0;
  int unsigned full_beats    = 0;
  int unsigned failures      = 0;
  int unsigned idle_cycles   = 0;
  int unsigned op_seen [8]   = '{default: 0};

  // --------------------------------------------------------------------------
  // model
  // --------------------------------------------------------------------------

  function automatic result_t status_beat(byte_t data, logic has_data, logic took,
                                          logic last, len_t moved);
    result_t beat;
    len_t    occ;
    occ              = len_t'(wr_ptr - rd_ptr);
    beat.data_out    = data;
    beat.data_valid  = has_data;
    beat.accepted    = took;
    beat.occupancy   = occ;
    beat.is_full     = (occ == DEPTH);
    beat.is_empty    = (occ == 0);
    beat.last_of_run = last;
    beat.transferred = moved;
    return beat;
  endfunction

  function automatic logic ring_write(byte_t value);
    if (len_t'(wr_ptr - rd_ptr) >= DEPTH) return 1'b0;
    ring[wr_ptr[IDX_W-1:0]] = value;
    wr_ptr++;
    return 1'b1;
  endfunction

  // queue up every result beat one request causes, updating the ring
  function automatic void forecast_beats(request_t req);
    len_t  held;
    len_t  count;
    ptr_t  at;
    byte_t front;
    logic  stored;
    int    i;
    held = len_t'(wr_ptr - rd_ptr);
    case (req.op)
      OP_PUT: begin
        stored = ring_write(req.data);
        beats_due.push_back(status_beat('0, 1'b0, stored, 1'b1, '0));
      end
      OP_GET, OP_PEEK: begin
        if (held == 0) begin
          beats_due.push_back(status_beat('0, 1'b0, 1'b0, 1'b1, '0));
        end else begin
          front = ring[rd_ptr[IDX_W-1:0]];
          if (req.op == OP_GET) rd_ptr++;
          beats_due.push_back(status_beat(front, 1'b1, 1'b0, 1'b1, '0));
        end
      end
      OP_PULL, OP_PEEK_AHEAD: begin
        // run length: least of the request, the bytes held and one full run
        count = (req.len < held) ? req.len : held;
        if (count > MAX_RUN) count = len_t'(MAX_RUN);
        if (count == 0) begin
          beats_due.push_back(status_beat('0, 1'b0, 1'b0, 1'b1, '0));
        end else begin
          at = rd_ptr;
          for (i = 1; i <= count; i++) begin
            front = ring[at[IDX_W-1:0]];
            at++;
            if (req.op == OP_PULL) rd_ptr = at;
            beats_due.push_back(status_beat(front, 1'b1, 1'b0, i == count,
                                            (i == count) ? count : len_t'(0)));
          end
        end
      end
      OP_FLUSH: begin
        rd_ptr = wr_ptr;
        beats_due.push_back(status_beat('0, 1'b0, 1'b0, 1'b1, '0));
      end
      OP_ADD: begin
        // the first byte decides the whole burst against the free space
        if (req.first) begin
          burst_open = (req.blen != 0) && (req.blen <= DEPTH - held);
          burst_left = burst_open ? req.blen : '0;
        end
        stored = 1'b0;
        if (burst_open && burst_left != 0) begin
          stored = ring_write(req.data);   // a full ring drops the byte, it still counts
          burst_left--;
          if (burst_left == 0) burst_open = 1'b0;
        end
        beats_due.push_back(status_beat('0, 1'b0, stored, 1'b1, '0));
      end
      default: begin
        beats_due.push_back(status_beat('0, 1'b0, 1'b0, 1'b1, '0));
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------

  function automatic string show_beat(result_t b);
    return $sformatf("data %02h dv %0b acc %0b occ %0d full %0b empty %0b last %0b moved %0d",
                     b.data_out, b.data_valid, b.accepted, b.occupancy, b.is_full,
                     b.is_empty, b.last_of_run, b.transferred);
  endfunction

  function automatic void report_failure(string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  function automatic void check_beat(result_t got);
    result_t want;
    beats_checked++;
    if (beats_due.size() == 0) begin
      report_failure($sformatf("result beat %0d with nothing due: %s",
                               beats_checked, show_beat(got)));
    end else begin
      want = beats_due.pop_front();
      if (want.is_full) full_beats++;
      if (got.data_out    !== want.data_out    || got.data_valid  !== want.data_valid ||
          got.accepted    !== want.accepted    || got.occupancy   !== want.occupancy  ||
          got.is_full     !== want.is_full     || got.is_empty    !== want.is_empty   ||
          got.last_of_run !== want.last_of_run || got.transferred !== want.transferred) begin
        report_failure($sformatf("result beat %0d\n  expected %s\n  actual   %s",
                                 beats_checked, show_beat(want), show_beat(got)));
      end
    end
  endfunction

  // both channels are sampled at the rising edge, before this edge's updates
  always @(posedge clk_i) begin
    pin_t     pin;
    request_t req;
    result_t  got;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        req.op    = op_e'(req_if.operation);
        req.data  = req_if.data_in;
        req.len   = req_if.request_length;
        req.first = req_if.burst_first;
        req.blen  = req_if.burst_length;
        pin = pin_due.pop_front();
        forecast_beats(req);
        if (pin.pinned) beats_due[beats_due.size() - 1] = pin.beat;
        op_seen[req_if.operation]++;
      end
      if (res_if.valid && res_if.ready) begin
        got = {res_if.data_out, res_if.data_valid, res_if.accepted, res_if.occupancy,
               res_if.is_full, res_if.is_empty, res_if.last_of_run, res_if.transferred};
        check_beat(got);
      end
      beats_outstanding <= beats_due.size();
    end
  end

  // result side stalls at random except in the calm stretch
  always @(posedge clk_i) begin
    res_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // watchdog: too long without a beat on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no beat for %0d cycles, %0d result beats still due",
               idle_cycles, beats_due.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  function automatic byte_t rand_byte();
    return byte_t'($urandom());
  endfunction

  // mostly short lengths, now and then anything up to a full run
  function automatic len_t rand_len();
    return len_t'(($urandom_range(3) == 0) ? $urandom_range(64) : $urandom_range(8));
  endfunction

  // valid stays high from one beat to the next unless a gap is taken
  task automatic send_request(request_t req, logic pinned, result_t beat);
    pin_t pin;
    pin.pinned = pinned;
    pin.beat   = beat;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pin_due.push_back(pin);
    req_if.valid          <= 1'b1;
    req_if.operation      <= req.op;
    req_if.data_in        <= req.data;
    req_if.request_length <= req.len;
    req_if.burst_first    <= req.first;
    req_if.burst_length   <= req.blen;
    items_sent++;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic send_op(op_e op, byte_t data, len_t len, logic first, len_t blen);
    request_t req;
    req.op    = op;
    req.data  = data;
    req.len   = len;
    req.first = first;
    req.blen  = blen;
    send_request(req, 1'b0, '0);
  endtask

  // hold off until every result beat due has come back
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (beats_outstanding != 0);
  endtask

  // fill the ring with one 64-byte burst, then run the full-ring cases
  task automatic fill_and_overflow();
    wait_drained();
    send_op(OP_FLUSH, rand_byte(), rand_len(), 1'b0, rand_len());
    calm <= 1'b1;
    send_op(OP_ADD, rand_byte(), rand_len(), 1'b1, len_t'(DEPTH));
    repeat (DEPTH - 1) send_op(OP_ADD, rand_byte(), rand_len(), 1'b0, rand_len());
    // ring full: a put and a new burst are turned away, so is the burst's next byte
    send_op(OP_PUT, rand_byte(), rand_len(), 1'b0, rand_len());
    send_op(OP_ADD, rand_byte(), rand_len(), 1'b1, 7'd1);
    send_op(OP_ADD, rand_byte(), rand_len(), 1'b0, rand_len());
    send_op(OP_PEEK_AHEAD, rand_byte(), len_t'(MAX_RUN), 1'b0, rand_len());
    calm <= 1'b0;
    // room for two: a two-byte burst gets in, a put takes the last slot,
    // the burst's second byte then finds the ring full and closes the burst
    send_op(OP_PULL, rand_byte(), 7'd2, 1'b0, rand_len());
    send_op(OP_ADD, rand_byte(), rand_len(), 1'b1, 7'd2);
    send_op(OP_PUT, rand_byte(), rand_len(), 1'b0, rand_len());
    send_op(OP_ADD, rand_byte(), rand_len(), 1'b0, rand_len());
    send_op(OP_GET, rand_byte(), rand_len(), 1'b0, rand_len());
    send_op(OP_PEEK, rand_byte(), rand_len(), 1'b0, rand_len());
    send_op(OP_PULL, rand_byte(), len_t'(MAX_RUN), 1'b0, rand_len());
    wait_drained();
  endtask

  task automatic random_episode();
    int unsigned span;
    int unsigned sent;
    int unsigned i;
    case ($urandom_range(9))
      0, 1: begin
        // noise: any code, any fields
        send_op(op_e'($urandom_range(7)), rand_byte(), rand_len(),
                1'($urandom_range(1)), rand_len());
      end
      2, 3, 4: begin
        // add burst, sometimes cut short or overrun, with other requests mixed in
        span = $urandom_range(1, 16);
        sent = ($urandom_range(4) == 0) ? $urandom_range(span + 2) : span;
        send_op(OP_ADD, rand_byte(), rand_len(), 1'b1, len_t'(span));
        for (i = 1; i < sent; i++) begin
          if ($urandom_range(5) == 0)
            send_op(op_e'($urandom_range(int'(OP_PUT), int'(OP_PEEK))), rand_byte(),
                    rand_len(), 1'b0, rand_len());
          send_op(OP_ADD, rand_byte(), rand_len(), 1'b0, rand_len());
        end
      end
      5, 6: begin
        repeat ($urandom_range(1, 8))
          send_op(OP_PUT, rand_byte(), rand_len(), 1'($urandom_range(1)), rand_len());
      end
      7, 8: begin
        send_op(op_e'($urandom_range(int'(OP_GET), int'(OP_PEEK_AHEAD))), rand_byte(),
                rand_len(), 1'($urandom_range(1)), rand_len());
      end
      default: begin
        case ($urandom_range(2))
          0: send_op(OP_FLUSH, rand_byte(), rand_len(), 1'($urandom_range(1)), rand_len());
          1: send_op(OP_ADD, rand_byte(), rand_len(), 1'b1, 7'd0);
          default: wait_drained();
        endcase
      end
    endcase
  endtask

  initial begin
    logic filled;
    filled                = 1'b0;
    calm                  = 1'b0;
    rst_ni                = 1'b0;
    req_if.valid          = 1'b0;
    req_if.operation      = OP_PUT;
    req_if.data_in        = '0;
    req_if.request_length = '0;
    req_if.burst_first    = 1'b0;
    req_if.burst_length   = '0;
    res_if.ready          = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_request(directed[i].req, directed[i].pinned, directed[i].beat);
    wait_drained();

    while (items_sent < N_STEPS + RANDOM_ITEMS) begin
      if (!filled && items_sent >= N_STEPS + FILL_AFTER) begin
        fill_and_overflow();
        filled = 1'b1;
      end else begin
        random_episode();
      end
    end

    // drain, then leave room for any stray beat to show up
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (beats_due.size() != 0)
      report_failure($sformatf("%0d result beats never arrived", beats_due.size()));

    $display("requests: %0d put, %0d get, %0d peek, %0d pull, %0d peek ahead, %0d flush, %0d add, %0d reserved",
             op_seen[OP_PUT], op_seen[OP_GET], op_seen[OP_PEEK], op_seen[OP_PULL],
             op_seen[OP_PEEK_AHEAD], op_seen[OP_FLUSH], op_seen[OP_ADD],
             op_seen[OP_RESERVED]);
    $display("result beats checked: %0d, %0d of them with the ring full, %0d failures",
             beats_checked, full_beats, failures);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
